// File: rtl/ulcv_pkg.sv
// Shared types, codes and the CRC32 nibble table for the upload verifier.
`default_nettype none

package ulcv_pkg;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_ABORT = 2'd3;

    // Status codes reported in a result item.
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_ABORT   = 3'd4;

    // Reset values.
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [31:0] CRC_PRESET    = 32'hFFFF_FFFF;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic [31:0] expected_length;
        logic [31:0] expected_crc;
    } ulcv_in_t;

    typedef struct packed {
        logic        finished;
        logic [2:0]  status;
        logic [31:0] bytes_received;
        logic [31:0] computed_crc;
    } ulcv_out_t;

    // Reflected CRC32 (polynomial 0xEDB88320) contribution of one nibble.
    function automatic logic [31:0] nib_lookup(input logic [3:0] idx);
        logic [31:0] val;
        unique case (idx)
            4'h0: val = 32'h0000_0000;
            4'h1: val = 32'h1DB7_1064;
            4'h2: val = 32'h3B6E_20C8;
            4'h3: val = 32'h26D9_30AC;
            4'h4: val = 32'h76DC_4190;
            4'h5: val = 32'h6B6B_51F4;
            4'h6: val = 32'h4DB2_6158;
            4'h7: val = 32'h5005_713C;
            4'h8: val = 32'hEDB8_8320;
            4'h9: val = 32'hF00F_9344;
            4'hA: val = 32'hD6D6_A3E8;
            4'hB: val = 32'hCB61_B38C;
            4'hC: val = 32'h9B64_C2B0;
            4'hD: val = 32'h86D3_D2D4;
            4'hE: val = 32'hA00A_E278;
            4'hF: val = 32'hBDBD_F21C;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ulcv_crc_byte.sv
// Folds one byte into a running reflected CRC32 with two nibble lookups.
`default_nettype none

module ulcv_crc_byte (
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  byte_in,
    output logic      [31:0] crc_out
);
    import ulcv_pkg::*;

    logic [31:0] mixed;
    logic [31:0] half;

    // Merge the byte into the low bits, then consume it a nibble at a time.
    always_comb begin
        mixed   = crc_in ^ {24'd0, byte_in};
        half    = nib_lookup(mixed[3:0]) ^ {4'd0, mixed[31:4]};
        crc_out = nib_lookup(half[3:0]) ^ {4'd0, half[31:4]};
    end

endmodule

`default_nettype wire

// File: rtl/upload_length_crc32_verifier_unit.sv
// Upload length and CRC32 verifier: top level with state and result register.
//
// Usage: the host sends items on the s_ channel. A start item loads the
// expected length and CRC32 and begins a transfer; data items carry one byte
// each; tick items count idle time; an abort item ends the transfer. Every
// accepted item produces exactly one result item on the m_ channel, in order.
// A result reports finished, a status code, the byte count so far and, when
// finished, the final CRC32.
// The result is registered at the edge that accepts the item. Throughput is one
// item per cycle while the receiver takes results, set by the single result register;
// the byte fold, count compare and CRC compare all fit between the state
// registers and that result register.
// When the receiver stalls, the result register holds its item and s_ready
// drops until it is taken; s_ready stays high while the result is being taken.
// The cfg channel writes the timeout register and is always ready; write it
// only while no transfer item is outstanding.
// Reset (aresetn low, synchronous) empties the result register, ends any
// transfer and sets the timeout register to 1000 ticks.
`default_nettype none

module upload_length_crc32_verifier_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ulcv_pkg::ulcv_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ulcv_pkg::ulcv_out_t    m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [15:0]       cfg_data
);
    import ulcv_pkg::*;

    logic        busy_reg,     busy_next;
    logic [31:0] target_len_reg, target_len_next;
    logic [31:0] target_crc_reg, target_crc_next;
    logic [31:0] count_reg,    count_next;
    logic [31:0] crc_reg,      crc_next;
    logic [15:0] idle_reg,     idle_next;
    logic [15:0] timeout_reg;
    logic        m_valid_reg;
    ulcv_out_t   out_reg,      out_next;
    logic        accept;
    logic [31:0] crc_folded;
    logic [31:0] count_inc;
    logic [15:0] idle_inc;

    // The result register frees itself when its item is taken.
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    ulcv_crc_byte u_crc_byte (
        .crc_in  (crc_reg),
        .byte_in (s_data.data_byte),
        .crc_out (crc_folded)
    );

    assign count_inc = count_reg + 32'd1;
    assign idle_inc  = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    // Next transfer state and the result item for the offered input item.
    always_comb begin
        busy_next       = busy_reg;
        target_len_next = target_len_reg;
        target_crc_next = target_crc_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        idle_next       = idle_reg;
        out_next.finished       = 1'b0;
        out_next.status         = ST_NONE;
        out_next.computed_crc   = 32'd0;

        if (s_data.opcode == OP_START) begin
            busy_next       = 1'b1;
            target_len_next = s_data.expected_length;
            target_crc_next = s_data.expected_crc;
            count_next      = 32'd0;
            crc_next        = CRC_PRESET;
            idle_next       = 16'd0;
            // A zero-length transfer is judged at once on the preset CRC.
            if (s_data.expected_length == 32'd0) begin
                busy_next             = 1'b0;
                out_next.finished     = 1'b1;
                out_next.computed_crc = 32'd0;
                out_next.status = (s_data.expected_crc == 32'd0) ? ST_OK : ST_CRC;
            end
        end else if (busy_reg) begin
            unique case (s_data.opcode)
                OP_DATA: begin
                    crc_next   = crc_folded;
                    count_next = count_inc;
                    idle_next  = 16'd0;
                    if (count_inc == target_len_reg) begin
                        busy_next             = 1'b0;
                        out_next.finished     = 1'b1;
                        out_next.computed_crc = ~crc_folded;
                        out_next.status = (~crc_folded == target_crc_reg) ? ST_OK : ST_CRC;
                    end
                end
                OP_TICK: begin
                    idle_next = idle_inc;
                    if (idle_inc > timeout_reg) begin
                        busy_next             = 1'b0;
                        out_next.finished     = 1'b1;
                        out_next.status       = ST_TIMEOUT;
                        out_next.computed_crc = ~crc_reg;
                    end
                end
                OP_ABORT: begin
                    busy_next             = 1'b0;
                    out_next.finished     = 1'b1;
                    out_next.status       = ST_ABORT;
                    out_next.computed_crc = ~crc_reg;
                end
                default: begin
                    busy_next = busy_reg;
                end
            endcase
        end
        out_next.bytes_received = count_next;
    end

    // Transfer state, updated only when an item is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            target_len_reg <= 32'd0;
            target_crc_reg <= 32'd0;
            count_reg      <= 32'd0;
            crc_reg        <= CRC_PRESET;
            idle_reg       <= 16'd0;
        end else if (accept) begin
            busy_reg       <= busy_next;
            target_len_reg <= target_len_next;
            target_crc_reg <= target_crc_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            idle_reg       <= idle_next;
        end
    end

    // Timeout register written from the configuration channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    // A finished result always carries a final status.
    a_finished_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.finished) |-> (m_data.status != ST_NONE))
        else $error("finished result without a final status");

    // A result that does not finish a transfer reports no CRC.
    a_running_crc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.finished) |-> (m_data.computed_crc == 32'd0))
        else $error("unfinished result carries a CRC");

    // A data byte during a transfer advances the byte count by one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && busy_reg && s_data.opcode == OP_DATA)
        |=> (count_reg == $past(count_reg) + 32'd1))
        else $error("byte count did not advance on a data item");

endmodule

`default_nettype wire

// File: bench/upload_length_crc32_verifier_unit_tb.sv
// Self-checking testbench for the upload length and CRC32 verifier unit.
`timescale 1ns / 1ps

module upload_length_crc32_verifier_unit_tb;

    import ulcv_pkg::*;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam int          RESET_CYCLES   = 9;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_PERIOD    = 1000;
    localparam int          HOLD_CYCLES    = 400;

    // Expected upload state and the queue of reports still to come back.
    class upload_score;
        logic        busy;
        logic [31:0] goal_length;
        logic [31:0] goal_crc;
        logic [31:0] byte_count;
        logic [31:0] crc_reg;
        logic [15:0] idle_ticks;
        logic [15:0] timeout_limit;
        ulcv_out_t   pending_reports[$];
        int          live_items;
        int          results_seen;
        int          errors;
        int          ended[5];

        function new();
            busy          = 1'b0;
            goal_length   = '0;
            goal_crc      = '0;
            byte_count    = '0;
            crc_reg       = CRC_PRESET;
            idle_ticks    = '0;
            timeout_limit = TIMEOUT_RESET;
        endfunction

        // Bit-serial reflected CRC32 update over one byte.
        function logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout_limit = value;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // Ends the transfer and builds the closing report.
        function ulcv_out_t close_transfer(logic [2:0] status);
            ulcv_out_t r;
            busy             = 1'b0;
            r.finished       = 1'b1;
            r.status         = status;
            r.bytes_received = byte_count;
            r.computed_crc   = crc_reg ^ CRC_PRESET;
            ended[status]++;
            return r;
        endfunction

        function ulcv_out_t verdict();
            return close_transfer(((crc_reg ^ CRC_PRESET) == goal_crc) ? ST_OK : ST_CRC);
        endfunction

        // Works out the report that one accepted input item causes.
        function void note_item(ulcv_in_t item);
            ulcv_out_t r;
            if (item.opcode == OP_START || busy) live_items++;
            r.finished     = 1'b0;
            r.status       = ST_NONE;
            r.computed_crc = '0;
            if (item.opcode == OP_START) begin
                busy        = 1'b1;
                goal_length = item.expected_length;
                goal_crc    = item.expected_crc;
                byte_count  = '0;
                crc_reg     = CRC_PRESET;
                idle_ticks  = '0;
                if (goal_length == 32'd0) r = verdict();
            end else if (busy && item.opcode == OP_DATA) begin
                crc_reg    = fold_byte(crc_reg, item.data_byte);
                byte_count = byte_count + 32'd1;
                idle_ticks = '0;
                if (byte_count == goal_length) r = verdict();
            end else if (busy && item.opcode == OP_TICK) begin
                if (idle_ticks != IDLE_MAX) idle_ticks = idle_ticks + 16'd1;
                if (idle_ticks > timeout_limit) r = close_transfer(ST_TIMEOUT);
            end else if (busy) begin
                r = close_transfer(ST_ABORT);
            end
            r.bytes_received = byte_count;
            pending_reports.push_back(r);
        endfunction

        task report(input string field, input logic [31:0] got, input logic [31:0] want);
            $display("[%0t] result %0d: %s is %h, expected %h",
                     $time, results_seen, field, got, want);
            errors++;
        endtask

        // Compares one accepted result item with the oldest expected report.
        task check_result(input ulcv_out_t got);
            ulcv_out_t want;
            results_seen++;
            if (pending_reports.size() == 0) begin
                report("unexpected result item", 32'(got.status), 32'(ST_NONE));
                return;
            end
            want = pending_reports.pop_front();
            if (got.finished !== want.finished)
                report("finished", 32'(got.finished), 32'(want.finished));
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.bytes_received !== want.bytes_received)
                report("bytes_received", got.bytes_received, want.bytes_received);
            if (got.computed_crc !== want.computed_crc)
                report("computed_crc", got.computed_crc, want.computed_crc);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ulcv_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    ulcv_out_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    upload_score book = new();
    int          burst_left = 0;
    int          cur_timeout = TIMEOUT_RESET;

    upload_length_crc32_verifier_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic ulcv_in_t make_item(logic [1:0] op, logic [7:0] b,
                                           logic [31:0] len, logic [31:0] crc);
        ulcv_in_t item;
        item.opcode          = op;
        item.data_byte       = b;
        item.expected_length = len;
        item.expected_crc    = crc;
        return item;
    endfunction

    // Offers one item and waits for it to be taken; the sender may idle between bursts.
    task automatic send_item(input ulcv_in_t item);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        book.note_item(item);
        burst_left--;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(make_item(OP_TICK, 8'($urandom), $urandom, $urandom));
    endtask

    // Stops offering items and lets every outstanding report come back.
    task automatic settle();
        s_valid    <= 1'b0;
        burst_left  = 0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid <= 1'b0;
        book.set_timeout(value);
        cur_timeout = int'(value);
    endtask

    // One upload with random bytes, idle ticks, and now and then an abort, a restart,
    // a run of ticks up to or just past the timeout, or trailing noise.
    task automatic run_transfer();
        logic [7:0]  payload[$];
        logic [31:0] sum;
        int          len;
        int          cut;
        int          style;
        int          ticks;
        int          extra;
        len   = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 20);
        style = $urandom_range(0, 9);
        cut   = $urandom_range(0, len);
        sum   = CRC_PRESET;
        for (int i = 0; i < len; i++) begin
            payload.push_back(8'($urandom_range(0, 255)));
            sum = book.fold_byte(sum, payload[i]);
        end
        sum = sum ^ CRC_PRESET;
        if ($urandom_range(0, 2) == 0)
            sum = ($urandom_range(0, 1) == 1) ? $urandom : sum ^ (32'd1 << $urandom_range(0, 31));
        send_item(make_item(OP_START, 8'($urandom), len, sum));
        for (int i = 0; i < len; i++) begin
            if (i == cut && style == 0) begin
                send_item(make_item(OP_ABORT, 8'($urandom), $urandom, $urandom));
                break;
            end
            if (i == cut && style == 1) begin
                send_item(make_item(OP_START, 8'($urandom), $urandom, $urandom));
                break;
            end
            ticks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            if (i == cut && style == 2 && cur_timeout < 40)
                ticks = cur_timeout + $urandom_range(0, 1);
            send_ticks(ticks);
            send_item(make_item(OP_DATA, payload[i], $urandom, $urandom));
        end
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (extra)
            send_item(make_item(2'($urandom_range(1, 3)), 8'($urandom), $urandom, $urandom));
    endtask

    task automatic random_phase(input int quota);
        int first;
        first = book.live_items;
        while (book.live_items - first < quota) run_transfer();
    endtask

    // Receiver: checks each taken result and stalls on a changing pattern,
    // with a long hold-off now and then so that the block backs up.
    initial begin
        int mode;
        int hold_left;
        int cyc;
        mode      = 0;
        hold_left = 0;
        cyc       = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
                book.check_result(m_data);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (cyc % HOLD_PERIOD == HOLD_PERIOD / 2) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= cyc[0];
                endcase
            end
        end
    end

    // Watchdog: ends the run when no channel has moved an item for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence.
    initial begin
        logic [31:0] sum;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Data, tick and abort with no transfer open are ignored.
        send_item(make_item(OP_DATA, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_TICK, 8'h00, 32'h0, 32'h0));
        send_item(make_item(OP_ABORT, 8'h5A, 32'h0, 32'h0));

        // Zero-length uploads finish at once, matching only a claimed CRC of zero.
        send_item(make_item(OP_START, 8'h00, 32'd0, 32'd0));
        send_item(make_item(OP_START, 8'hFF, 32'd0, 32'hFFFF_FFFF));
        send_item(make_item(OP_DATA, 8'h12, 32'd0, 32'd0));

        // A good three-byte upload, then a stray byte that keeps the count.
        sum = book.fold_byte(book.fold_byte(book.fold_byte(CRC_PRESET, 8'h00), 8'hFF), 8'hA5);
        send_item(make_item(OP_START, 8'h00, 32'd3, sum ^ CRC_PRESET));
        send_item(make_item(OP_DATA, 8'h00, 32'd0, 32'd0));
        send_item(make_item(OP_DATA, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_DATA, 8'hA5, 32'd0, 32'd0));
        send_item(make_item(OP_DATA, 8'h3C, 32'd0, 32'd0));

        // A two-byte upload with a wrong claimed CRC.
        send_item(make_item(OP_START, 8'h00, 32'd2, 32'hFFFF_FFFF));
        send_item(make_item(OP_DATA, 8'h31, 32'd0, 32'd0));
        send_item(make_item(OP_DATA, 8'h32, 32'd0, 32'd0));

        // A start while busy drops the huge transfer without a closing report.
        sum = book.fold_byte(CRC_PRESET, 8'h80) ^ CRC_PRESET;
        send_item(make_item(OP_START, 8'h00, 32'hFFFF_FFFF, 32'd0));
        send_item(make_item(OP_DATA, 8'h00, 32'd0, 32'd0));
        send_item(make_item(OP_START, 8'h00, 32'd1, sum));
        send_item(make_item(OP_DATA, 8'h80, 32'd0, 32'd0));

        // Abort in the middle, then an abort with nothing open.
        send_item(make_item(OP_START, 8'h00, 32'd5, 32'h1234_5678));
        send_item(make_item(OP_DATA, 8'h7F, 32'd0, 32'd0));
        send_ticks(2);
        send_item(make_item(OP_ABORT, 8'h00, 32'd0, 32'd0));
        send_item(make_item(OP_ABORT, 8'h00, 32'd0, 32'd0));

        // With the reset timeout a few idle ticks leave the upload open until an abort.
        send_item(make_item(OP_START, 8'h00, 32'd4, 32'd0));
        send_ticks(5);
        send_item(make_item(OP_ABORT, 8'h00, 32'd0, 32'd0));

        // A timeout of zero expires on the very first tick.
        write_timeout(16'd0);
        send_item(make_item(OP_START, 8'h00, 32'd2, 32'd0));
        send_ticks(1);
        random_phase(80);

        // At the top setting idle ticks leave the upload running to a good end.
        write_timeout(16'hFFFF);
        sum = book.fold_byte(book.fold_byte(CRC_PRESET, 8'hC3), 8'h3C) ^ CRC_PRESET;
        send_item(make_item(OP_START, 8'h00, 32'd2, sum));
        send_ticks(4);
        send_item(make_item(OP_DATA, 8'hC3, 32'd0, 32'd0));
        send_item(make_item(OP_DATA, 8'h3C, 32'd0, 32'd0));

        // Random uploads under several timeout settings.
        write_timeout(16'd1);
        random_phase(200);
        write_timeout(16'($urandom_range(2, 12)));
        random_phase(320);
        write_timeout(16'($urandom_range(0, 16'hFFFF)));
        random_phase(200);

        settle();
        $display("Checked %0d results against %0d live items; timeout set to 1000, 0, 65535, 1",
                 book.results_seen, book.live_items);
        $display("and random values. Closed: %0d ok, %0d crc mismatch, %0d timeout, %0d aborted.",
                 book.ended[ST_OK], book.ended[ST_CRC], book.ended[ST_TIMEOUT],
                 book.ended[ST_ABORT]);
        if (book.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ulcv_pkg.sv
rtl/ulcv_crc_byte.sv
rtl/upload_length_crc32_verifier_unit.sv
bench/upload_length_crc32_verifier_unit_tb.sv
